[design/assert_macros.svh]
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/kmse_pkg.sv]
package kmse_pkg;

    localparam int MAX_ITEMS_DEF = 256;
    localparam int MAX_DIMS_DEF  = 8;

    localparam logic [3:0] K_LOAD_W  = 4'd0;
    localparam logic [3:0] K_LOAD_C  = 4'd1;
    localparam logic [3:0] K_LOAD_P  = 4'd2;
    localparam logic [3:0] K_ADD     = 4'd3;
    localparam logic [3:0] K_REMOVE  = 4'd4;
    localparam logic [3:0] K_CHECK   = 4'd5;
    localparam logic [3:0] K_CHKADD  = 4'd6;
    localparam logic [3:0] K_RD_SEL  = 4'd7;
    localparam logic [3:0] K_RD_UNS  = 4'd8;
    localparam logic [3:0] K_RD_RES  = 4'd9;
    localparam logic [3:0] K_CLEAR   = 4'd10;

    localparam logic REG_ITEM_COUNT = 1'b0;
    localparam logic REG_DIM_COUNT  = 1'b1;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  item;
        logic [2:0]  dimension;
        logic [7:0]  position;
        logic [23:0] amount;
    } t_cmd_item;

    typedef struct packed {
        logic [3:0]  violations;
        logic        changed;
        logic [23:0] total_value;
        logic [8:0]  selected_count;
        logic [23:0] read_value;
    } t_result;

    typedef struct packed {
        logic capture;
        logic ck_step;
        logic move;
        logic scan;
        logic rs_step;
        logic rd_res;
        logic lread;
        logic clr_start;
        logic sweep;
    } t_dp_cmd;

    typedef struct packed {
        logic [3:0] kind;
        logic       item_ok;
        logic       move_go;
        logic       ck_pass;
        logic       dim_last;
        logic       scan_last;
        logic       sweep_last;
    } t_dp_status;

endpackage

[design/knapsack_solution_move_engine.sv]
// Multidimensional knapsack move engine. Issue an item with start while busy is low; exactly
// one result follows, shown for a single cycle with o_result_valid, and it must be taken then.
// A check steps through the D active dimensions. An add or remove scans the list the item
// leaves (its order-keeping compaction reads one list entry per cycle) and then updates the
// resource sums of the D dimensions; a check-and-add adds the item only if its check passes.
// Clear sweeps all MAX_ITEMS list slots to rebuild the unchosen list. After reset the same
// sweep runs with busy high before the first item is taken; configuration writes are taken
// at any time.
module knapsack_solution_move_engine #(
    parameter int MAX_ITEMS = kmse_pkg::MAX_ITEMS_DEF,
    parameter int MAX_DIMS  = kmse_pkg::MAX_DIMS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  kmse_pkg::t_cmd_item i_cmd,
    output logic                o_result_valid,
    output kmse_pkg::t_result   o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [8:0] r_item_count;
    logic [3:0] r_dim_count;
    logic       cfg_we;

    kmse_pkg::t_dp_cmd    dp_cmd;
    kmse_pkg::t_dp_status dp_status;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= 9'd256;
            r_dim_count  <= 4'd8;
        end else if (cfg_we) begin
            case (paddr[2])
                kmse_pkg::REG_ITEM_COUNT: r_item_count <= pwdata[8:0];
                kmse_pkg::REG_DIM_COUNT:  r_dim_count  <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            kmse_pkg::REG_ITEM_COUNT: prdata = 32'(r_item_count);
            kmse_pkg::REG_DIM_COUNT:  prdata = 32'(r_dim_count);
            default:                  prdata = '0;
        endcase
    end

    kmse_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_status       (dp_status),
        .o_cmd          (dp_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    kmse_datapath #(
        .MAX_ITEMS (MAX_ITEMS),
        .MAX_DIMS  (MAX_DIMS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_item   (i_cmd),
        .i_item_count (r_item_count),
        .i_dim_count  (r_dim_count),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .o_result     (o_result)
    );

endmodule

[design/kmse_datapath.sv]
`include "assert_macros.svh"

module kmse_datapath #(
    parameter int MAX_ITEMS = kmse_pkg::MAX_ITEMS_DEF,
    parameter int MAX_DIMS  = kmse_pkg::MAX_DIMS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kmse_pkg::t_cmd_item i_cmd_item,
    input  logic [8:0]          i_item_count,
    input  logic [3:0]          i_dim_count,
    input  kmse_pkg::t_dp_cmd   i_cmd,
    output kmse_pkg::t_dp_status o_status,
    output kmse_pkg::t_result   o_result
);

    localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NW  = $clog2(MAX_DIMS + 1);
    localparam int XW  = (IW > 8) ? IW : 8;
    localparam int DXW = (DW > 3) ? DW : 3;
    localparam int RST_ITEMS = (MAX_ITEMS < 256) ? MAX_ITEMS : 256;

    // memories
    logic [15:0]   m_weight   [0:(2**(DW+IW))-1];
    logic [15:0]   m_profit   [0:(2**IW)-1];
    logic          m_member   [0:(2**IW)-1];
    logic [IW-1:0] m_chosen   [0:(2**IW)-1];
    logic [IW-1:0] m_unchosen [0:(2**IW)-1];

    logic [15:0]   r_wq;
    logic [15:0]   r_pq;
    logic          r_mq;
    logic [IW-1:0] r_cq;
    logic [IW-1:0] r_uq;

    logic [23:0]   r_cap [0:MAX_DIMS-1];
    logic [23:0]   r_res [0:MAX_DIMS-1];
    logic [23:0]   r_profit;
    logic [CW-1:0] r_ctot;
    logic [CW-1:0] r_utot;

    logic [3:0]    r_kind;
    logic [IW-1:0] r_item;
    logic          r_item_ok;
    logic          r_dim_ok;
    logic          r_pos_ok_c;
    logic          r_pos_ok_u;
    logic [DW-1:0] r_dcnt;
    logic [CW-1:0] r_scan;
    logic [IW-1:0] r_qidx;
    logic          r_qv;
    logic          r_found;
    logic [NW-1:0] r_viol;
    logic          r_changed;
    logic [23:0]   r_read;

    logic [XW-1:0]  item_x;
    logic [IW-1:0]  item_idx;
    logic [XW-1:0]  pos_x;
    logic [DXW-1:0] dim_x;
    logic [DW-1:0]  dim_idx;
    logic           load_item_ok;
    logic           dim_ok;
    logic [CW-1:0]  eff_items;
    logic [NW-1:0]  eff_dims;
    logic           is_add;
    logic           do_move;
    logic           hit;
    logic           dim_last;
    logic [IW-1:0]  lq;
    logic [CW-1:0]  tot;
    logic           match;
    logic           found_now;
    logic           scan_last;
    logic           sweep_last;
    logic           push_c;
    logic           push_u;
    logic           cmp_c;
    logic           cmp_u;
    logic           w_we;
    logic           p_we;

    always_comb begin
        if (i_item_count == '0) begin
            eff_items = CW'(1);
        end else if (32'(i_item_count) > MAX_ITEMS) begin
            eff_items = CW'(MAX_ITEMS);
        end else begin
            eff_items = CW'(i_item_count);
        end
        if (i_dim_count == '0) begin
            eff_dims = NW'(1);
        end else if (32'(i_dim_count) > MAX_DIMS) begin
            eff_dims = NW'(MAX_DIMS);
        end else begin
            eff_dims = NW'(i_dim_count);
        end
    end

    assign item_x       = XW'(i_cmd_item.item);
    assign item_idx     = item_x[IW-1:0];
    assign pos_x        = XW'(i_cmd_item.position);
    assign dim_x        = DXW'(i_cmd_item.dimension);
    assign dim_idx      = dim_x[DW-1:0];
    assign load_item_ok = 32'(i_cmd_item.item) < MAX_ITEMS;
    assign dim_ok       = 32'(i_cmd_item.dimension) < MAX_DIMS;

    assign is_add   = (r_kind == kmse_pkg::K_ADD) || (r_kind == kmse_pkg::K_CHKADD);
    assign do_move  = is_add ? !r_mq : r_mq;
    // capacity test on the unwrapped sum
    assign hit      = ({1'b0, r_res[r_dcnt]} + {9'b0, r_wq}) > {1'b0, r_cap[r_dcnt]};
    assign dim_last = (32'(r_dcnt) + 1) == 32'(eff_dims);

    assign lq        = is_add ? r_uq : r_cq;
    assign tot       = is_add ? r_utot : r_ctot;
    assign match     = lq == r_item;
    assign found_now = r_found || (r_qv && match);
    assign scan_last = (tot == '0) || (r_qv && (32'(r_qidx) + 1 == 32'(tot)));
    assign sweep_last = 32'(r_scan) == MAX_ITEMS - 1;

    assign push_c = i_cmd.move && do_move && is_add && (32'(r_ctot) < MAX_ITEMS);
    assign push_u = i_cmd.move && do_move && !is_add && (32'(r_utot) < MAX_ITEMS);
    // compaction: each entry after the match moves down by one
    assign cmp_c  = i_cmd.scan && !is_add && r_qv && r_found;
    assign cmp_u  = i_cmd.scan && is_add && r_qv && r_found;

    assign w_we = i_cmd.capture && (i_cmd_item.kind == kmse_pkg::K_LOAD_W) && dim_ok
                  && load_item_ok;
    assign p_we = i_cmd.capture && (i_cmd_item.kind == kmse_pkg::K_LOAD_P) && load_item_ok;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            m_weight[{dim_idx, item_idx}] <= i_cmd_item.amount[15:0];
        end
        r_wq <= m_weight[{r_dcnt, r_item}];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            m_profit[item_idx] <= i_cmd_item.amount[15:0];
        end
        r_pq <= m_profit[r_item];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            m_member[r_scan[IW-1:0]] <= 1'b0;
        end else if (i_cmd.move && do_move) begin
            m_member[r_item] <= is_add;
        end
        r_mq <= m_member[r_item];
    end

    always_ff @(posedge i_clk) begin
        if (push_c) begin
            m_chosen[r_ctot[IW-1:0]] <= r_item;
        end else if (cmp_c) begin
            m_chosen[r_qidx - IW'(1)] <= r_cq;
        end
        r_cq <= m_chosen[r_scan[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            m_unchosen[r_scan[IW-1:0]] <= (32'(r_scan) < 32'(eff_items)) ?
                                          r_scan[IW-1:0] : '0;
        end else if (push_u) begin
            m_unchosen[r_utot[IW-1:0]] <= r_item;
        end else if (cmp_u) begin
            m_unchosen[r_qidx - IW'(1)] <= r_uq;
        end
        r_uq <= m_unchosen[r_scan[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && (i_cmd_item.kind == kmse_pkg::K_LOAD_C) && dim_ok) begin
            r_cap[dim_idx] <= i_cmd_item.amount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctot    <= '0;
            r_utot    <= CW'(RST_ITEMS);
            r_profit  <= '0;
            r_scan    <= '0;
            r_qv      <= 1'b0;
            r_found   <= 1'b0;
            r_dcnt    <= '0;
            r_viol    <= '0;
            r_changed <= 1'b0;
            r_read    <= '0;
            r_kind    <= kmse_pkg::K_LOAD_W;
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_res[d] <= '0;
            end
        end else begin
            if (i_cmd.capture) begin
                r_kind     <= i_cmd_item.kind;
                r_item     <= item_idx;
                r_item_ok  <= 32'(i_cmd_item.item) < 32'(eff_items);
                r_dim_ok   <= dim_ok;
                r_pos_ok_c <= (32'(i_cmd_item.position) < 32'(r_ctot))
                              && (32'(i_cmd_item.position) < MAX_ITEMS);
                r_pos_ok_u <= (32'(i_cmd_item.position) < 32'(r_utot))
                              && (32'(i_cmd_item.position) < MAX_ITEMS);
                r_dcnt     <= ((i_cmd_item.kind == kmse_pkg::K_RD_RES) && dim_ok) ?
                              dim_idx : '0;
                r_scan     <= ((i_cmd_item.kind == kmse_pkg::K_RD_SEL)
                               || (i_cmd_item.kind == kmse_pkg::K_RD_UNS)) ?
                              CW'(pos_x[IW-1:0]) : '0;
                r_qv       <= 1'b0;
                r_found    <= 1'b0;
                r_viol     <= '0;
                r_changed  <= 1'b0;
                r_read     <= '0;
            end
            if (i_cmd.ck_step) begin
                r_viol <= r_viol + NW'(hit);
                r_dcnt <= dim_last ? '0 : r_dcnt + DW'(1);
            end
            if (i_cmd.move) begin
                r_scan  <= '0;
                r_qv    <= 1'b0;
                r_found <= 1'b0;
                r_dcnt  <= '0;
                if (do_move) begin
                    r_changed <= 1'b1;
                    if (is_add) begin
                        r_profit <= r_profit + 24'(r_pq);
                        if (push_c) begin
                            r_ctot <= r_ctot + CW'(1);
                        end
                    end else begin
                        r_profit <= r_profit - 24'(r_pq);
                        if (push_u) begin
                            r_utot <= r_utot + CW'(1);
                        end
                    end
                end
            end
            if (i_cmd.scan) begin
                r_qidx <= r_scan[IW-1:0];
                r_qv   <= 1'b1;
                r_scan <= r_scan + CW'(1);
                if (r_qv && match) begin
                    r_found <= 1'b1;
                end
                if (scan_last && found_now) begin
                    if (is_add) begin
                        r_utot <= r_utot - CW'(1);
                    end else begin
                        r_ctot <= r_ctot - CW'(1);
                    end
                end
            end
            if (i_cmd.rs_step) begin
                r_res[r_dcnt] <= is_add ? r_res[r_dcnt] + 24'(r_wq)
                                        : r_res[r_dcnt] - 24'(r_wq);
                r_dcnt <= dim_last ? '0 : r_dcnt + DW'(1);
            end
            if (i_cmd.rd_res) begin
                r_read <= r_dim_ok ? r_res[r_dcnt] : '0;
            end
            if (i_cmd.lread) begin
                if (r_kind == kmse_pkg::K_RD_SEL) begin
                    r_read <= r_pos_ok_c ? 24'(r_cq) : '0;
                end else begin
                    r_read <= r_pos_ok_u ? 24'(r_uq) : '0;
                end
            end
            if (i_cmd.clr_start) begin
                r_changed <= r_ctot != '0;
                r_ctot    <= '0;
                r_utot    <= eff_items;
                r_profit  <= '0;
                for (int d = 0; d < MAX_DIMS; d++) begin
                    r_res[d] <= '0;
                end
            end
            if (i_cmd.sweep) begin
                r_scan <= r_scan + CW'(1);
            end
        end
    end

    assign o_status.kind       = r_kind;
    assign o_status.item_ok    = r_item_ok;
    assign o_status.move_go    = do_move;
    assign o_status.ck_pass    = (r_viol == '0) && !hit;
    assign o_status.dim_last   = dim_last;
    assign o_status.scan_last  = scan_last;
    assign o_status.sweep_last = sweep_last;

    assign o_result.violations     = 4'(r_viol);
    assign o_result.changed        = r_changed;
    assign o_result.total_value    = r_profit;
    assign o_result.selected_count = 9'(r_ctot);
    assign o_result.read_value     = r_read;

    `ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push_c, r_ctot == $past(r_ctot) + CW'(1))
    `ASSERT_NEXT(a_capture_clears, i_clk, i_rst_n, i_cmd.capture, (r_read == '0) && !r_changed && (r_viol == '0))
    `ASSERT_IMPLY(a_res_in_range, i_clk, i_rst_n, i_cmd.rs_step || i_cmd.ck_step, 32'(r_dcnt) < 32'(eff_dims))

endmodule

[design/kmse_ctrl.sv]
`include "assert_macros.svh"

module kmse_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  kmse_pkg::t_dp_status i_status,
    output kmse_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy,
    output logic                 o_result_valid
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_CKA   = 4'd2;
    localparam logic [3:0] S_CKB   = 4'd3;
    localparam logic [3:0] S_MOVE  = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_RSA   = 4'd6;
    localparam logic [3:0] S_RSB   = 4'd7;
    localparam logic [3:0] S_LREAD = 4'd8;
    localparam logic [3:0] S_CLR   = 4'd9;
    localparam logic [3:0] S_INIT  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                case (i_status.kind)
                    kmse_pkg::K_ADD, kmse_pkg::K_REMOVE: begin
                        n_state = i_status.item_ok ? S_MOVE : S_DONE;
                    end
                    kmse_pkg::K_CHECK, kmse_pkg::K_CHKADD: begin
                        n_state = i_status.item_ok ? S_CKA : S_DONE;
                    end
                    kmse_pkg::K_RD_SEL, kmse_pkg::K_RD_UNS: begin
                        n_state = S_LREAD;
                    end
                    kmse_pkg::K_RD_RES: begin
                        o_cmd.rd_res = 1'b1;
                        n_state      = S_DONE;
                    end
                    kmse_pkg::K_CLEAR: begin
                        o_cmd.clr_start = 1'b1;
                        n_state         = S_CLR;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CKA: begin
                n_state = S_CKB;
            end
            S_CKB: begin
                o_cmd.ck_step = 1'b1;
                if (!i_status.dim_last) begin
                    n_state = S_CKA;
                end else if ((i_status.kind == kmse_pkg::K_CHKADD) && i_status.ck_pass) begin
                    n_state = S_MOVE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = i_status.move_go ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_RSA;
                end
            end
            S_RSA: begin
                n_state = S_RSB;
            end
            S_RSB: begin
                o_cmd.rs_step = 1'b1;
                n_state       = i_status.dim_last ? S_DONE : S_RSA;
            end
            S_LREAD: begin
                o_cmd.lread = 1'b1;
                n_state     = S_DONE;
            end
            S_CLR: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy         = r_state != S_IDLE;
    assign o_result_valid = r_state == S_DONE;

    `ASSERT_NEXT(a_done_one_cycle, i_clk, i_rst_n, r_state == S_DONE, r_state == S_IDLE)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && (r_state == S_IDLE), r_state == S_DISP)
    `ASSERT_NEXT(a_clear_reports, i_clk, i_rst_n, (r_state == S_CLR) && i_status.sweep_last, r_state == S_DONE)

endmodule
